FILE: rtl/core/fixed_point_square_root_q16_core_defines.svh
// Assertion macros for the square root core top level
`ifndef FIXED_POINT_SQUARE_ROOT_Q16_CORE_DEFINES_SVH
`define FIXED_POINT_SQUARE_ROOT_Q16_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define FSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FSR_ASSERT_IMP(lbl, ante, cons, msg) \
	`FSR_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define FSR_ASSERT(lbl, prop, msg)
`define FSR_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/fsr_pkg.sv
// Types and constants of the fixed-point square root core
package fsr_pkg;

	localparam int NEWTON_STEPS = 12;
	localparam int CELL_STAGES  = 3;
	// accept edge to the edge that samples done
	localparam int LATENCY      = CELL_STAGES * NEWTON_STEPS + 5;

	localparam logic [3:0]         FRAC_BITS_RESET   = 4'd15;
	localparam logic signed [15:0] HALF_ROOT_TWO_Q15 = 16'sd23170;
	localparam logic signed [17:0] ROOT_TWO_Q15      = 18'sd46340;
	localparam logic signed [16:0] THREE_EIGHTHS_Q15 = 17'sd12288;
	localparam logic signed [16:0] ONE_HALF_Q15      = 17'sd16384;

	// per-sample context carried alongside the estimate
	typedef struct packed {
		logic        valid;
		logic        zero;
		logic [14:0] norm;
		logic [2:0]  half_shift;
	} ctx_t;

endpackage

FILE: rtl/core/fsr_front.sv
// Normalization and initial reciprocal square root guess
module fsr_front import fsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic signed [15:0] value,
	output ctx_t               ctx,
	output logic signed [15:0] y
);

	logic [3:0]  msb;
	logic [3:0]  lead;
	logic [14:0] norm_d;
	ctx_t        ctx_s1;
	ctx_t        ctx_s2;
	logic signed [16:0] diff;
	logic signed [32:0] prod;
	logic signed [15:0] y_s2;

	always_comb begin
		msb = 4'd0;
		for (int i = 0; i < 15; i++) begin
			if (value[i]) begin
				msb = 4'(i);
			end
		end
		lead   = 4'd14 - msb;
		norm_d = value[14:0] << {lead[3:1], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s1 <= '0;
			ctx_s2 <= '0;
		end else begin
			ctx_s1.valid      <= take;
			ctx_s1.zero       <= (value == 16'sd0) || value[15];
			ctx_s1.norm       <= norm_d;
			ctx_s1.half_shift <= lead[3:1];
			ctx_s2            <= ctx_s1;
		end
	end

	always_ff @(posedge clk) begin
		y_s2 <= HALF_ROOT_TWO_Q15 - prod[30:15];
	end

	// linear guess around one half
	assign diff = $signed({2'b00, ctx_s1.norm}) - ONE_HALF_Q15;
	assign prod = HALF_ROOT_TWO_Q15 * diff;

	assign ctx = ctx_s2;
	assign y   = y_s2;

endmodule

FILE: rtl/core/fsr_newton_cell.sv
// One Newton step on the reciprocal square root estimate, three stages
module fsr_newton_cell import fsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctx_t               ctx_in,
	input  logic signed [15:0] y_in,
	output ctx_t               ctx_out,
	output logic signed [15:0] y_out
);

	ctx_t               ctx_s1;
	ctx_t               ctx_s2;
	ctx_t               ctx_s3;
	logic signed [15:0] y_s1;
	logic signed [15:0] y_s2;
	logic signed [15:0] y_s3;
	logic signed [15:0] sq_s1;
	logic signed [15:0] t_s2;
	logic signed [31:0] sq_prod;
	logic signed [31:0] t_prod;
	logic signed [16:0] corr;
	logic signed [32:0] y_prod;
	logic signed [15:0] half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s1 <= '0;
			ctx_s2 <= '0;
			ctx_s3 <= '0;
		end else begin
			ctx_s1 <= ctx_in;
			ctx_s2 <= ctx_s1;
			ctx_s3 <= ctx_s2;
		end
	end

	assign sq_prod = y_in * y_in;
	assign half    = $signed({2'b00, ctx_s1.norm[14:1]});
	assign t_prod  = sq_s1 * half;
	assign corr    = THREE_EIGHTHS_Q15 - $signed({t_s2[15], t_s2});
	assign y_prod  = y_s2 * corr;

	always_ff @(posedge clk) begin
		y_s1  <= y_in;
		sq_s1 <= sq_prod[30:15];
		y_s2  <= y_s1;
		t_s2  <= t_prod[30:15];
		// shift down by 15, times four, keep 16 bits
		y_s3  <= {y_prod[28:15], 2'b00};
	end

	assign ctx_out = ctx_s3;
	assign y_out   = y_s3;

endmodule

FILE: rtl/core/fsr_back.sv
// Multiply by the operand, rescale for the format and undo normalization
module fsr_back import fsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         frac_bits,
	input  ctx_t               ctx_in,
	input  logic signed [15:0] y_in,
	output logic               done,
	output logic [14:0]        root
);

	ctx_t               ctx_s1;
	ctx_t               ctx_s2;
	logic signed [15:0] y_s1;
	logic signed [15:0] y_s2;
	logic signed [30:0] n_prod;
	logic [4:0]         ib;
	logic signed [15:0] y_fmt;
	logic signed [15:0] y_shr;
	logic signed [33:0] r_prod;
	logic signed [15:0] y_fin;
	logic               done_q;
	logic [14:0]        root_q;

	assign n_prod = $signed({1'b0, ctx_in.norm}) * y_in;
	assign ib     = 5'd16 - {1'b0, frac_bits};
	assign y_shr  = y_s1 >>> ib[4:1];
	assign r_prod = y_shr * ROOT_TWO_Q15;
	assign y_fin  = y_s2 >>> ctx_s2.half_shift;

	always_comb begin
		y_fmt = y_s1;
		if (ib > 5'd1) begin
			y_fmt = ib[0] ? y_shr : r_prod[30:15];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s1 <= '0;
			ctx_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctx_s1 <= ctx_in;
			ctx_s2 <= ctx_s1;
			done_q <= ctx_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		y_s1   <= {n_prod[29:15], 1'b0};
		y_s2   <= y_fmt;
		// drop the estimate for non-positive operands
		root_q <= ctx_s2.zero ? 15'd0 : y_fin[14:0];
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/core/fixed_point_square_root_q16_core.sv
// Top level of the pipelined fixed-point square root core
//
//  channel   signals                           transfer
//  -------   -------------------------------   ------------------------
//  input     start, busy, value[15:0]          start && !busy
//  result    done, root[14:0]                  done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data    cfg_valid && cfg_ready
//
// One sample enters per cycle; busy stays low.
// The pipeline has two front stages, three per Newton cell (one multiplier
// each) and three back stages.
// Reset clears all valid flags and sets frac_bits to 15.
// Results cannot be stalled; done pulses for one cycle per sample.
`include "fixed_point_square_root_q16_core_defines.svh"
module fixed_point_square_root_q16_core import fsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] value,
	output logic               done,
	output logic [14:0]        root,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data
);

	logic               take;
	logic [3:0]         frac_bits_q;
	ctx_t               ctx_chain [NEWTON_STEPS+1];
	logic signed [15:0] y_chain   [NEWTON_STEPS+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_bits_q <= FRAC_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frac_bits_q <= cfg_data;
		end
	end

	fsr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.value  (value),
		.ctx    (ctx_chain[0]),
		.y      (y_chain[0])
	);

	for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_cell
		fsr_newton_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctx_in  (ctx_chain[g]),
			.y_in    (y_chain[g]),
			.ctx_out (ctx_chain[g+1]),
			.y_out   (y_chain[g+1])
		);
	end

	fsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.frac_bits (frac_bits_q),
		.ctx_in    (ctx_chain[NEWTON_STEPS]),
		.y_in      (y_chain[NEWTON_STEPS]),
		.done      (done),
		.root      (root)
	);

	`FSR_ASSERT_IMP(a_done_follows_take, done, $past(take, LATENCY), "result without a transfer")
	`FSR_ASSERT_IMP(a_nonpos_zero, done && $past(value == 16'sd0 || value[15], LATENCY), root == 15'd0, "non-positive sample gave nonzero root")
	`FSR_ASSERT_IMP(a_chain_valid, ctx_chain[NEWTON_STEPS].valid, $past(ctx_chain[0].valid, CELL_STAGES * NEWTON_STEPS), "valid lost in Newton chain")

endmodule
